>>> sv/c_comment_stripper_line_splicer_top_defines.svh
// Assertion macros used by the checker file.
`ifndef C_COMMENT_STRIPPER_LINE_SPLICER_TOP_DEFINES_SVH
`define C_COMMENT_STRIPPER_LINE_SPLICER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CCSLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CCSLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ccsls_pkg.sv
`default_nettype none
package ccsls_pkg;

    localparam int unsigned LINE_BITS_DEF = 24;
    localparam int unsigned MAX_RES       = 4;
    localparam logic [15:0] MAX_LEN_RST   = 16'd4096;
    localparam logic [15:0] MAX_LEN_MIN   = 16'd2;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_UNTERM = 2'd1,
        ERR_LONG   = 2'd2,
        ERR_WRAP   = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_STAR   = 2'd2,
        MODE_LINE   = 2'd3
    } t_mode;

    // Results of one request, as handed to the result buffer.
    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  bytes;
        logic [3:0]       ends;
        logic [3:0][1:0]  errs;
        logic [23:0]      line_no;
    } t_batch;

    // Scanner working state while one request is evaluated.
    typedef struct packed {
        t_mode            mode;
        logic             held_slash;
        logic [15:0]      fill;
        logic             wrapped;
        logic [2:0]       n;
        logic [3:0][7:0]  bytes;
        logic [3:0]       ends;
        logic [3:0][1:0]  errs;
    } t_work;

endpackage
`default_nettype wire

>>> sv/ccsls_scan.sv
`default_nettype none
module ccsls_scan #(
    parameter int unsigned LINE_BITS = ccsls_pkg::LINE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_eof,
    input  wire logic [15:0]          i_max_len,
    output ccsls_pkg::t_batch         o_batch
);

    ccsls_pkg::t_mode     r_mode;
    logic                 r_held_slash;
    logic                 r_held_bs;
    logic [LINE_BITS-1:0] r_line_count;
    logic [15:0]          r_fill;
    logic                 r_wrapped;

    ccsls_pkg::t_work     n_work;
    logic                 n_held_bs;
    logic [LINE_BITS-1:0] n_line_count;
    logic                 count_inc;
    logic [15:0]          lim;

    function automatic ccsls_pkg::t_work f_emit(ccsls_pkg::t_work w, logic [7:0] b,
                                                 logic e, ccsls_pkg::t_err err);
        ccsls_pkg::t_work r;
        ccsls_pkg::t_err  er;
        r  = w;
        er = err;
        if (w.n < 3'(ccsls_pkg::MAX_RES)) begin
            if (er == ccsls_pkg::ERR_NONE && r.wrapped) begin
                er        = ccsls_pkg::ERR_WRAP;
                r.wrapped = 1'b0;
            end
            r.bytes[w.n[1:0]] = b;
            r.ends[w.n[1:0]]  = e;
            r.errs[w.n[1:0]]  = er;
            r.n               = w.n + 3'd1;
        end
        return r;
    endfunction

    function automatic ccsls_pkg::t_work f_end_line(ccsls_pkg::t_work w,
                                                     ccsls_pkg::t_err err);
        ccsls_pkg::t_work r;
        r      = f_emit(w, ccsls_pkg::CH_NL, 1'b1, err);
        r.fill = '0;
        return r;
    endfunction

    function automatic ccsls_pkg::t_work f_content(ccsls_pkg::t_work w, logic [7:0] b,
                                                    logic [15:0] lm);
        ccsls_pkg::t_work r;
        r      = f_emit(w, b, 1'b0, ccsls_pkg::ERR_NONE);
        r.fill = r.fill + 16'd1;
        if (r.fill >= lm) begin
            r = f_end_line(r, ccsls_pkg::ERR_LONG);
        end
        return r;
    endfunction

    function automatic ccsls_pkg::t_work f_deliver(ccsls_pkg::t_work w, logic [7:0] c,
                                                    logic [15:0] lm);
        ccsls_pkg::t_work r;
        logic             done;
        r    = w;
        done = 1'b0;
        case (w.mode)
            ccsls_pkg::MODE_BLOCK: begin
                if (c == ccsls_pkg::CH_STAR) r.mode = ccsls_pkg::MODE_STAR;
            end
            ccsls_pkg::MODE_STAR: begin
                if (c == ccsls_pkg::CH_SLASH) begin
                    r.mode = ccsls_pkg::MODE_NORMAL;
                    r      = f_content(r, ccsls_pkg::CH_SPACE, lm);
                end else if (c != ccsls_pkg::CH_STAR) begin
                    r.mode = ccsls_pkg::MODE_BLOCK;
                end
            end
            ccsls_pkg::MODE_LINE: begin
                if (c == ccsls_pkg::CH_NL) begin
                    r.mode = ccsls_pkg::MODE_NORMAL;
                    r      = f_content(r, ccsls_pkg::CH_SPACE, lm);
                    r      = f_end_line(r, ccsls_pkg::ERR_NONE);
                end
            end
            default: begin
                if (r.held_slash) begin
                    r.held_slash = 1'b0;
                    if (c == ccsls_pkg::CH_STAR) begin
                        r.mode = ccsls_pkg::MODE_BLOCK;
                        done   = 1'b1;
                    end else if (c == ccsls_pkg::CH_SLASH) begin
                        r.mode = ccsls_pkg::MODE_LINE;
                        done   = 1'b1;
                    end else begin
                        r = f_content(r, ccsls_pkg::CH_SLASH, lm);
                    end
                end
                if (!done) begin
                    if (c == ccsls_pkg::CH_SLASH) begin
                        r.held_slash = 1'b1;
                    end else if (c == ccsls_pkg::CH_NL) begin
                        r = f_end_line(r, ccsls_pkg::ERR_NONE);
                    end else begin
                        r = f_content(r, c, lm);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Line count advances on every physical newline, spliced or not.
    always_comb begin
        lim          = (i_max_len < ccsls_pkg::MAX_LEN_MIN) ? ccsls_pkg::MAX_LEN_MIN
                                                             : i_max_len;
        count_inc    = !i_eof && (i_byte == ccsls_pkg::CH_NL);
        n_line_count = r_line_count + LINE_BITS'(count_inc);
    end

    // Next state of the scanner and the results of this request.
    always_comb begin
        ccsls_pkg::t_err eof_err;
        n_work.mode       = r_mode;
        n_work.held_slash = r_held_slash;
        n_work.fill       = r_fill;
        n_work.wrapped    = r_wrapped || (count_inc && (n_line_count == '0));
        n_work.n          = '0;
        n_work.bytes      = '0;
        n_work.ends       = '0;
        n_work.errs       = '0;
        n_held_bs         = r_held_bs;
        eof_err           = ccsls_pkg::ERR_NONE;
        if (i_eof) begin
            if (r_held_bs) n_work = f_deliver(n_work, ccsls_pkg::CH_BSLASH, lim);
            if (n_work.held_slash) begin
                n_work.held_slash = 1'b0;
                n_work            = f_content(n_work, ccsls_pkg::CH_SLASH, lim);
            end
            if (n_work.mode == ccsls_pkg::MODE_BLOCK || n_work.mode == ccsls_pkg::MODE_STAR)
                eof_err = ccsls_pkg::ERR_UNTERM;
            if (n_work.mode != ccsls_pkg::MODE_NORMAL)
                n_work = f_content(n_work, ccsls_pkg::CH_SPACE, lim);
            n_work.mode = ccsls_pkg::MODE_NORMAL;
            n_work      = f_end_line(n_work, eof_err);
            n_held_bs   = 1'b0;
        end else if (r_held_bs && i_byte == ccsls_pkg::CH_NL) begin
            // Splice: drop both bytes.
            n_held_bs = 1'b0;
        end else begin
            if (r_held_bs) n_work = f_deliver(n_work, ccsls_pkg::CH_BSLASH, lim);
            if (i_byte == ccsls_pkg::CH_BSLASH) begin
                n_held_bs = 1'b1;
            end else begin
                n_held_bs = 1'b0;
                n_work    = f_deliver(n_work, i_byte, lim);
            end
        end
    end

    always_comb begin
        o_batch.n       = n_work.n;
        o_batch.bytes   = n_work.bytes;
        o_batch.ends    = n_work.ends;
        o_batch.errs    = n_work.errs;
        o_batch.line_no = 24'(n_line_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ccsls_pkg::MODE_NORMAL;
            r_held_slash <= 1'b0;
            r_held_bs    <= 1'b0;
            r_line_count <= '0;
            r_fill       <= '0;
            r_wrapped    <= 1'b0;
        end else if (i_load) begin
            r_mode       <= n_work.mode;
            r_held_slash <= n_work.held_slash;
            r_held_bs    <= n_held_bs;
            r_line_count <= n_line_count;
            r_fill       <= n_work.fill;
            r_wrapped    <= n_work.wrapped;
        end
    end

endmodule
`default_nettype wire

>>> sv/ccsls_res_buf.sv
`default_nettype none
module ccsls_res_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  ccsls_pkg::t_batch       i_batch,
    output logic                    o_free,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [31:0]             o_tdata,   // out_byte[7:0], line_number[31:8]
    output logic [2:0]              o_tuser,   // line_end[0], error_code[2:1]
    output logic                    o_tlast
);

    ccsls_pkg::t_batch r_batch;
    logic [2:0]        r_left;
    logic [1:0]        r_idx;
    logic              take;

    always_comb begin
        o_tvalid = (r_left != 3'd0);
        take     = o_tvalid && i_tready;
        o_free   = (r_left == 3'd0) || (r_left == 3'd1 && take);
        o_tdata  = {r_batch.line_no, r_batch.bytes[r_idx]};
        o_tuser  = {r_batch.errs[r_idx], r_batch.ends[r_idx]};
        o_tlast  = (r_left == 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_batch.n;
            r_idx  <= '0;
        end else if (take) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_batch <= i_batch;
    end

endmodule
`default_nettype wire

>>> sv/c_comment_stripper_line_splicer_top.sv
// A request passes the input register, then the result buffer. Throughput: one
//   request per cycle while each gives at most one result and the master is ready;
//   one that gives k results (up to 4, on flushes and forced line ends) holds the
//   result register while they drain; the one-entry input register takes the next.
// Reset: synchronous, active low; clears scanner state, line count and buffers,
//   and sets max_line_len to 4096.
`default_nettype none
module c_comment_stripper_line_splicer_top #(
    parameter int unsigned LINE_BITS = ccsls_pkg::LINE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: max_line_len
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // Source bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  wire logic [0:0]  s_axis_tuser,   // end_of_file[0]
    // Cleaned lines
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // out_byte[7:0], line_number[31:8]
    output logic [2:0]       m_axis_tuser,   // line_end[0], error_code[2:1]
    output logic             m_axis_tlast    // last_of_run
);

    logic [15:0]       r_max_len;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eof;
    logic              buf_free;
    logic              load;
    ccsls_pkg::t_batch batch;

    // Hand the held request to the scanner once the result buffer can take
    // its results; the input register refills in the same cycle.
    always_comb begin
        load          = r_in_valid && buf_free;
        s_axis_tready = !r_in_valid || buf_free;
    end

    // Configuration register, to be written by the user only while idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ccsls_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // Input register: hold the request until the scanner consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eof  <= s_axis_tuser[0];
        end
    end

    // Scanner: state registers plus the single-pass evaluation of one byte.
    ccsls_scan #(
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_byte    (r_in_byte),
        .i_eof     (r_in_eof),
        .i_max_len (r_max_len),
        .o_batch   (batch)
    );

    // Result buffer: drain the results of one request, one per cycle while the master is ready.
    ccsls_res_buf u_res_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_batch  (batch),
        .o_free   (buf_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> sv/ccsls_chk.sv
`default_nettype none
`include "c_comment_stripper_line_splicer_top_defines.svh"
module ccsls_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    `CCSLS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    `CCSLS_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty result buffer")
    `CCSLS_ASSERT_NOW(a_end_is_nl, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[7:0] == ccsls_pkg::CH_NL, "line end without newline")
    `CCSLS_ASSERT_NOW(a_err_on_end, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[2:1] == ccsls_pkg::ERR_UNTERM || m_axis_tuser[2:1] == ccsls_pkg::ERR_LONG), m_axis_tuser[0], "line error off a line end")

endmodule

bind c_comment_stripper_line_splicer_top ccsls_chk u_ccsls_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
